### rtl/delta_sleep_timer_queue_top_defines.svh
// assertion macros for the delta sleep timer queue
`ifndef DELTA_SLEEP_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_SLEEP_TIMER_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DSTQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dstq assertion failed");
`define DSTQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dstq assertion failed");
`else
`define DSTQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define DSTQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/dstq_pkg.sv
package dstq_pkg;

   localparam int PID_W       = 4;
   localparam int DELAY_W     = 16;
   localparam int DELTA_W     = 17;
   localparam int TPS_W       = 8;
   localparam int MAX_RESULTS = 16;
   localparam int COUNT_W     = 5;
   localparam logic [TPS_W-1:0] TPS_RESET = 8'd60;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SLP_FREE,
      ST_SLP_WALK,
      ST_SLP_INS,
      ST_SLP_LINK,
      ST_SEC_FIRST,
      ST_SEC_NEXT,
      ST_EMIT_EMPTY,
      ST_EMIT_REFUSED,
      ST_EMIT_WAKE
   } state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_FREE,
      RD_LINK
   } rd_src_type;

   typedef enum logic [1:0] {
      OUT_EMPTY,
      OUT_REFUSED,
      OUT_WAKE
   } out_kind_type;

   typedef struct packed {
      logic         req_take;
      logic         rd_en;
      rd_src_type   rd_src;
      logic         tick_step;
      logic         count_clr;
      logic         sec_dec;
      logic         pop;
      logic         slp_start;
      logic         walk_step;
      logic         walk_break;
      logic         ins_node;
      logic         ins_link;
      logic         out_load;
      out_kind_type out_kind;
      logic         out_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic func;
      logic second_due;
      logic free_nil;
      logic head_nil;
      logic link_nil;
      logic delta_zero;
      logic delta_le1;
      logic rem_lt;
      logic count_last;
      logic slot_free;
   } ctl_sts_type;

endpackage

### rtl/dstq_req_if.sv
interface dstq_req_if;
   import dstq_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [PID_W-1:0]   proc_id;
   logic [DELAY_W-1:0] delay_seconds;

   modport source (output valid, func, proc_id, delay_seconds, input ready);
   modport sink (input valid, func, proc_id, delay_seconds, output ready);
endinterface

### rtl/dstq_rsp_if.sv
interface dstq_rsp_if;
   import dstq_pkg::*;

   logic             valid;
   logic             ready;
   logic             wake_valid;
   logic [PID_W-1:0] woken_id;
   logic             refused;
   logic             last;

   modport source (output valid, wake_valid, woken_id, refused, last, input ready);
   modport sink (input valid, wake_valid, woken_id, refused, last, output ready);
endinterface

### rtl/dstq_ram.sv
module dstq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dstq_ctl.sv
module dstq_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dstq_pkg::ctl_sts_type sts,
   output dstq_pkg::ctl_cmd_type cmd
);
   import dstq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.func) begin
               if (sts.free_nil) begin
                  state_in = ST_EMIT_REFUSED;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_src = RD_FREE;
                  state_in   = ST_SLP_FREE;
               end
            end else begin
               cmd.tick_step = 1'b1;
               cmd.count_clr = 1'b1;
               if (!sts.second_due || sts.head_nil) begin
                  state_in = ST_EMIT_EMPTY;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_src = RD_HEAD;
                  state_in   = ST_SEC_FIRST;
               end
            end
         end
         ST_SLP_FREE: begin
            cmd.slp_start = 1'b1;
            if (sts.head_nil) begin
               state_in = ST_SLP_INS;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = RD_HEAD;
               state_in   = ST_SLP_WALK;
            end
         end
         ST_SLP_WALK: begin
            if (sts.rem_lt) begin
               cmd.walk_break = 1'b1;
               state_in       = ST_SLP_INS;
            end else begin
               cmd.walk_step = 1'b1;
               if (sts.link_nil) begin
                  state_in = ST_SLP_INS;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_src = RD_LINK;
               end
            end
         end
         ST_SLP_INS: begin
            cmd.ins_node = 1'b1;
            state_in     = ST_SLP_LINK;
         end
         ST_SLP_LINK: begin
            cmd.ins_link = 1'b1;
            state_in     = ST_EMIT_EMPTY;
         end
         ST_SEC_FIRST: begin
            cmd.sec_dec = 1'b1;
            if (!sts.delta_le1) begin
               state_in = ST_EMIT_EMPTY;
            end else begin
               cmd.pop = 1'b1;
               if (sts.link_nil || sts.count_last) begin
                  state_in = ST_EMIT_WAKE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_src = RD_LINK;
                  state_in   = ST_SEC_NEXT;
               end
            end
         end
         ST_SEC_NEXT: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_WAKE;
               if (sts.delta_zero) begin
                  cmd.pop = 1'b1;
                  if (sts.link_nil || sts.count_last) begin
                     state_in = ST_EMIT_WAKE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_src = RD_LINK;
                  end
               end else begin
                  cmd.out_last = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_EMIT_EMPTY: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_EMPTY;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_REFUSED: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_REFUSED;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_WAKE: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_WAKE;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/dstq_dp.sv
module dstq_dp #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [dstq_pkg::TPS_W-1:0]    csr_wr_data,
   input  logic                          req_func,
   input  logic [dstq_pkg::PID_W-1:0]    req_proc_id,
   input  logic [dstq_pkg::DELAY_W-1:0]  req_delay_seconds,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_wake_valid,
   output logic [dstq_pkg::PID_W-1:0]    rsp_woken_id,
   output logic                          rsp_refused,
   output logic                          rsp_last,
   input  dstq_pkg::ctl_cmd_type         cmd,
   output dstq_pkg::ctl_sts_type         sts
);
   import dstq_pkg::*;

   localparam int ENTRY_W = $clog2(NUM_ENTRIES);
   localparam int LINK_W  = $clog2(NUM_ENTRIES + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_ENTRIES);

   logic [TPS_W-1:0]       tps_ff;
   logic [TPS_W-1:0]       tick_ff;
   logic [LINK_W-1:0]      head_ff;
   logic [LINK_W-1:0]      free_ff;
   logic [NUM_ENTRIES-1:0] link_valid_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   rsp_valid_ff;

   logic                   func_ff;
   logic [PID_W-1:0]       pid_ff;
   logic [DELAY_W-1:0]     delay_ff;
   logic [LINK_W-1:0]      node_ff;
   logic [LINK_W-1:0]      prev_ff;
   logic [LINK_W-1:0]      cur_ff;
   logic [LINK_W-1:0]      rd_addr_ff;
   logic [DELTA_W-1:0]     rem_ff;
   logic [PID_W-1:0]       wake_id_ff;
   logic                   rsp_wake_ff;
   logic [PID_W-1:0]       rsp_id_ff;
   logic                   rsp_refused_ff;
   logic                   rsp_last_ff;

   logic [TPS_W:0]         tick_next;
   logic                   second_due;
   logic [LINK_W-1:0]      rd_addr;
   logic [LINK_W-1:0]      link_q;
   logic [LINK_W-1:0]      link_rd;
   logic [DELTA_W-1:0]     delta_q;
   logic [PID_W-1:0]       owner_q;

   logic                   delta_we;
   logic [LINK_W-1:0]      delta_wa;
   logic [DELTA_W-1:0]     delta_wd;
   logic                   link_we;
   logic [LINK_W-1:0]      link_wa;
   logic [LINK_W-1:0]      link_wd;

   assign tick_next  = {1'b0, tick_ff} + (TPS_W + 1)'(1);
   assign second_due = tick_next >= {1'b0, tps_ff};

   always_comb begin
      case (cmd.rd_src)
         RD_HEAD: rd_addr = head_ff;
         RD_FREE: rd_addr = free_ff;
         RD_LINK: rd_addr = link_rd;
         default: rd_addr = head_ff;
      endcase
   end

   // links never written since reset follow the initial free chain
   assign link_rd = link_valid_ff[rd_addr_ff[ENTRY_W-1:0]] ? link_q
                                                           : rd_addr_ff + LINK_W'(1);

   always_comb begin
      delta_we = (cmd.sec_dec && (delta_q != '0)) || cmd.walk_break || cmd.ins_node;
      delta_wa = cmd.ins_node ? node_ff : cur_ff;
      if (cmd.ins_node) begin
         delta_wd = rem_ff;
      end else if (cmd.walk_break) begin
         delta_wd = delta_q - rem_ff;
      end else begin
         delta_wd = delta_q - DELTA_W'(1);
      end
   end

   always_comb begin
      link_we = cmd.pop || cmd.ins_node || (cmd.ins_link && (prev_ff != NIL));
      if (cmd.pop) begin
         link_wa = cur_ff;
         link_wd = free_ff;
      end else if (cmd.ins_node) begin
         link_wa = node_ff;
         link_wd = cur_ff;
      end else begin
         link_wa = prev_ff;
         link_wd = node_ff;
      end
   end

   dstq_ram #(.WIDTH(DELTA_W), .DEPTH(NUM_ENTRIES)) u_delta_ram (
      .clock   (clock),
      .wr_en   (delta_we),
      .wr_addr (delta_wa[ENTRY_W-1:0]),
      .wr_data (delta_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr[ENTRY_W-1:0]),
      .rd_data (delta_q)
   );

   dstq_ram #(.WIDTH(PID_W), .DEPTH(NUM_ENTRIES)) u_owner_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_node),
      .wr_addr (node_ff[ENTRY_W-1:0]),
      .wr_data (pid_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr[ENTRY_W-1:0]),
      .rd_data (owner_q)
   );

   dstq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa[ENTRY_W-1:0]),
      .wr_data (link_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr[ENTRY_W-1:0]),
      .rd_data (link_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= TPS_RESET;
         tick_ff       <= '0;
         head_ff       <= NIL;
         free_ff       <= '0;
         link_valid_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tps_ff <= csr_wr_data;
         end
         if (cmd.tick_step) begin
            tick_ff <= second_due ? '0 : tick_next[TPS_W-1:0];
         end
         if (cmd.pop) begin
            head_ff <= link_rd;
         end else if (cmd.ins_link && (prev_ff == NIL)) begin
            head_ff <= node_ff;
         end
         if (cmd.pop) begin
            free_ff <= cur_ff;
         end else if (cmd.slp_start) begin
            free_ff <= link_rd;
         end
         if (link_we) begin
            link_valid_ff[link_wa[ENTRY_W-1:0]] <= 1'b1;
         end
         if (cmd.count_clr) begin
            count_ff <= '0;
         end else if (cmd.pop) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         func_ff  <= req_func;
         pid_ff   <= req_proc_id;
         delay_ff <= req_delay_seconds;
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr;
         cur_ff     <= rd_addr;
      end else if (cmd.slp_start) begin
         cur_ff <= head_ff;
      end else if (cmd.walk_step) begin
         cur_ff <= link_rd;
      end
      if (cmd.slp_start) begin
         node_ff <= free_ff;
         prev_ff <= NIL;
         rem_ff  <= DELTA_W'(delay_ff);
      end else if (cmd.walk_step) begin
         prev_ff <= cur_ff;
         rem_ff  <= rem_ff - delta_q;
      end
      if (cmd.pop) begin
         wake_id_ff <= owner_q;
      end
      if (cmd.out_load) begin
         rsp_wake_ff    <= (cmd.out_kind == OUT_WAKE);
         rsp_id_ff      <= (cmd.out_kind == OUT_WAKE) ? wake_id_ff : '0;
         rsp_refused_ff <= (cmd.out_kind == OUT_REFUSED);
         rsp_last_ff    <= cmd.out_last;
      end
   end

   assign sts.func       = func_ff;
   assign sts.second_due = second_due;
   assign sts.free_nil   = (free_ff == NIL);
   assign sts.head_nil   = (head_ff == NIL);
   assign sts.link_nil   = (link_rd == NIL);
   assign sts.delta_zero = (delta_q == '0);
   assign sts.delta_le1  = (delta_q <= DELTA_W'(1));
   assign sts.rem_lt     = (rem_ff < delta_q);
   assign sts.count_last = (count_ff == COUNT_W'(MAX_RESULTS - 1));
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wake_valid = rsp_wake_ff;
   assign rsp_woken_id   = rsp_id_ff;
   assign rsp_refused    = rsp_refused_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### rtl/delta_sleep_timer_queue_top.sv
// tick: a second with wakes gives one result per woken entry
// sleep request: walks k queue entries, one link ram read each
// throughput: one request at a time, next request taken once its last result is registered
// reset: synchronous, clears the controller, prescaler, result register and queue head
// free list restored at once through per-entry link valid bits, no clearing pass
`include "delta_sleep_timer_queue_top_defines.svh"
module delta_sleep_timer_queue_top #(
   parameter int NUM_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [dstq_pkg::TPS_W-1:0] csr_wr_data,
   dstq_req_if.sink                   req_ch,
   dstq_rsp_if.source                 rsp_ch
);
   import dstq_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        req_ready;

   assign req_ch.ready = req_ready;

   dstq_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dstq_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_func          (req_ch.func),
      .req_proc_id       (req_ch.proc_id),
      .req_delay_seconds (req_ch.delay_seconds),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_wake_valid    (rsp_ch.wake_valid),
      .rsp_woken_id      (rsp_ch.woken_id),
      .rsp_refused       (rsp_ch.refused),
      .rsp_last          (rsp_ch.last),
      .cmd               (cmd),
      .sts               (sts)
   );

   `DSTQ_ASSERT_NXT(a_one_at_a_time, clock, reset, req_ch.valid && req_ready, !req_ready)
   `DSTQ_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, sts.slot_free)
   `DSTQ_ASSERT_IMP(a_no_nil_read, clock, reset, cmd.rd_en && (cmd.rd_src == RD_LINK),
                    !sts.link_nil)

endmodule
